[src/easgt_pkg.sv]
// ---------------------------------------------------------------------------
// easgt_pkg
// Shared constants and types for the event admission / sequence gap tracker.
// ---------------------------------------------------------------------------
package easgt_pkg;

  localparam int CAPACITY       = 16;
  localparam int NUM_CATEGORIES = 16;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int KEY_W = 64;
  localparam int VAL_W = 64;
  localparam int ADDR_W = 4;

  // status codes
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_EXPIRED  = 2'd2;
  localparam logic [1:0] ST_CATEGORY = 2'd3;

  // register indexes (decoded from paddr[3])
  localparam logic REG_CAT_ENABLE = 1'b0;
  localparam logic REG_EXPIRY     = 1'b1;

  typedef enum logic {
    ALU_SUB = 1'b0,
    ALU_ADD = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t          op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
    logic             cin;
  } alu_req_t;

  typedef struct packed {
    logic             key_en;
    logic             mark_en;
    logic [IDX_W-1:0] addr;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] mark;
  } tbl_wr_t;

endpackage

[src/easgt_alu.sv]
// ---------------------------------------------------------------------------
// easgt_alu
// Shared 64-bit add/subtract unit; bit 64 is carry (add) or borrow (sub).
// ---------------------------------------------------------------------------
module easgt_alu (
  input  easgt_pkg::alu_req_t        req,
  output logic [easgt_pkg::VAL_W:0]  res
);
  import easgt_pkg::*;

  logic [VAL_W:0] a_ext;
  logic [VAL_W:0] b_ext;
  logic [VAL_W:0] c_ext;

  assign a_ext = {1'b0, req.a};
  assign b_ext = {1'b0, req.b};
  assign c_ext = {{VAL_W{1'b0}}, req.cin};

  always_comb begin
    case (req.op)
      ALU_ADD: res = a_ext + b_ext + c_ext;
      ALU_SUB: res = a_ext - b_ext - c_ext;
      default: res = a_ext - b_ext - c_ext;
    endcase
  end

endmodule

[src/easgt_stream_table.sv]
// ---------------------------------------------------------------------------
// easgt_stream_table
// Stream key and high-mark storage, one write port, registered read.
// ---------------------------------------------------------------------------
module easgt_stream_table (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [easgt_pkg::IDX_W-1:0]   rd_addr,
  output logic [easgt_pkg::KEY_W-1:0]   rd_key,
  output logic [easgt_pkg::VAL_W-1:0]   rd_mark,
  input  easgt_pkg::tbl_wr_t            wr
);
  import easgt_pkg::*;

  logic [KEY_W-1:0] key_mem [CAPACITY];
  logic [VAL_W-1:0] mark_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr.key_en) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.mark_en) begin
      mark_mem[wr.addr] <= wr.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key  <= key_mem[rd_addr];
      rd_mark <= mark_mem[rd_addr];
    end
  end

endmodule

[src/event_admission_sequence_gap_tracker.sv]
// ---------------------------------------------------------------------------
// event_admission_sequence_gap_tracker
// Admits or rejects events and tracks per-stream sequence gaps.
//
// Usage: drive the event fields and pulse start while busy is low; the word
// is taken at that edge. Exactly one result word follows, shown for one cycle
// with out_valid high; the receiver cannot stall it. busy stays high until
// the result cycle, during which a new word may already be started.
// A rejected event goes from the expiry check straight to the result. An
// accepted event walks the stream table one entry per cycle through the
// shared subtractor (up to 16 streams in use). A new stream is then
// inserted; a known stream runs the gap subtract and, for a gap of more
// than one, the minus one and the saturating gap add on the same unit.
// Registers on the APB port: 0x0 category_enable, 0x8 expiry_time. The
// user must make writes only while no event is in flight (not enforced).
// Reset (rst_n low, synchronous) clears all counters, stream occupancy and
// the round-robin slot and restores the register defaults.
// ---------------------------------------------------------------------------
module event_admission_sequence_gap_tracker (
  input  logic                         clk,
  input  logic                         rst_n,
  // event input
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_event_well_formed,
  input  logic [3:0]                   in_category,
  input  logic [31:0]                  in_session_id,
  input  logic [31:0]                  in_process_id,
  input  logic [63:0]                  in_sequence_number,
  input  logic [63:0]                  in_now_time,
  // result
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [63:0]                  out_invalid_count,
  output logic [63:0]                  out_expired_count,
  output logic [63:0]                  out_category_reject_count,
  output logic [63:0]                  out_stream_eviction_count,
  output logic [63:0]                  out_gap_total,
  output logic                         out_gap_saturated,
  output logic [63:0]                  out_overwrite_count,
  output logic [63:0]                  out_accepted_count,
  output logic [easgt_pkg::CNT_W-1:0]  out_stored_events,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [easgt_pkg::ADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);
  import easgt_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EXP    = 9'b000000010,
    S_CMP    = 9'b000000100,
    S_GAP0   = 9'b000001000,
    S_GAP1   = 9'b000010000,
    S_GAP2   = 9'b000100000,
    S_INSERT = 9'b001000000,
    S_FIN    = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [15:0] cat_en_r;
  logic [63:0] expiry_r;
  logic        cfg_wr;

  // latched event
  logic              wf_r;
  logic [3:0]        cat_r;
  logic [KEY_W-1:0]  key_r;
  logic [63:0]       seq_r;
  logic [63:0]       now_r;

  // sequencer data
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [63:0]      tmp_r, tmp_nxt;
  logic [1:0]       status_r, status_nxt;

  // state
  logic [CNT_W-1:0] in_use_r, in_use_nxt;
  logic [IDX_W-1:0] repl_r, repl_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [63:0]      inv_cnt_r, inv_cnt_nxt;
  logic [63:0]      exp_cnt_r, exp_cnt_nxt;
  logic [63:0]      cat_cnt_r, cat_cnt_nxt;
  logic [63:0]      evict_r, evict_nxt;
  logic [63:0]      gap_r, gap_nxt;
  logic             sticky_r, sticky_nxt;
  logic [63:0]      ovw_r, ovw_nxt;
  logic [63:0]      acc_r, acc_nxt;

  // shared unit and table
  alu_req_t         alu_req;
  logic [VAL_W:0]   alu_res;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_mark;
  tbl_wr_t          tbl_wr;

  logic             take;
  logic             cat_ok;
  logic             last_entry;
  logic [IDX_W-1:0] ins_slot;

  easgt_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  easgt_stream_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_mark (rd_mark),
    .wr      (tbl_wr)
  );

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cat_en_r <= 16'hFFFF;
      expiry_r <= '1;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_CAT_ENABLE: cat_en_r <= pwdata[15:0];
        REG_EXPIRY:     expiry_r <= pwdata;
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3])
      REG_CAT_ENABLE: prdata = {48'd0, cat_en_r};
      REG_EXPIRY:     prdata = expiry_r;
      default:        prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  assign busy = (state_r != S_IDLE) && (state_r != S_DONE);
  assign take = start & ~busy;

  always_ff @(posedge clk) begin
    if (take) begin
      wf_r  <= in_event_well_formed;
      cat_r <= in_category;
      key_r <= {in_session_id, in_process_id};
      seq_r <= in_sequence_number;
      now_r <= in_now_time;
    end
  end

  assign cat_ok     = (int'(cat_r) < NUM_CATEGORIES) && cat_en_r[cat_r];
  assign last_entry = (CNT_W'(idx_r) + CNT_W'(1)) == in_use_r;
  assign ins_slot   = (in_use_r < CNT_W'(CAPACITY)) ? IDX_W'(in_use_r) : repl_r;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    tmp_nxt     = tmp_r;
    status_nxt  = status_r;
    in_use_nxt  = in_use_r;
    repl_nxt    = repl_r;
    fill_nxt    = fill_r;
    inv_cnt_nxt = inv_cnt_r;
    exp_cnt_nxt = exp_cnt_r;
    cat_cnt_nxt = cat_cnt_r;
    evict_nxt   = evict_r;
    gap_nxt     = gap_r;
    sticky_nxt  = sticky_r;
    ovw_nxt     = ovw_r;
    acc_nxt     = acc_r;

    alu_req.op  = ALU_SUB;
    alu_req.a   = now_r;
    alu_req.b   = expiry_r;
    alu_req.cin = 1'b0;

    rd_en   = 1'b0;
    rd_addr = '0;

    tbl_wr.key_en  = 1'b0;
    tbl_wr.mark_en = 1'b0;
    tbl_wr.addr    = idx_r;
    tbl_wr.key     = key_r;
    tbl_wr.mark    = seq_r;

    case (state_r)
      S_IDLE: begin
        if (take) begin
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        // now - expiry, no borrow means expired
        rd_en   = 1'b1;
        rd_addr = '0;
        idx_nxt = '0;
        if (!wf_r) begin
          inv_cnt_nxt = inv_cnt_r + 64'd1;
          status_nxt  = ST_INVALID;
          state_nxt   = S_DONE;
        end else if (!alu_res[VAL_W]) begin
          exp_cnt_nxt = exp_cnt_r + 64'd1;
          status_nxt  = ST_EXPIRED;
          state_nxt   = S_DONE;
        end else if (!cat_ok) begin
          cat_cnt_nxt = cat_cnt_r + 64'd1;
          status_nxt  = ST_CATEGORY;
          state_nxt   = S_DONE;
        end else begin
          status_nxt = ST_ACCEPTED;
          state_nxt  = (in_use_r == '0) ? S_INSERT : S_CMP;
        end
      end
      S_CMP: begin
        // compare entry idx_r, prefetch idx_r + 1 on a miss that is not the last; a hit keeps its mark
        alu_req.a = key_r;
        alu_req.b = rd_key;
        rd_addr   = idx_r + IDX_W'(1);
        if (alu_res[VAL_W-1:0] == '0) begin
          state_nxt = S_GAP0;
        end else if (last_entry) begin
          state_nxt = S_INSERT;
        end else begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_GAP0: begin
        alu_req.a = seq_r;
        alu_req.b = rd_mark;
        tmp_nxt   = alu_res[VAL_W-1:0];
        if (!alu_res[VAL_W] && (alu_res[VAL_W-1:0] != '0)) begin
          tbl_wr.mark_en = 1'b1;
        end
        if (!alu_res[VAL_W] && (alu_res[VAL_W-1:1] != '0)) begin
          state_nxt = S_GAP1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_GAP1: begin
        // missing = diff - 1
        alu_req.a = tmp_r;
        alu_req.b = 64'd1;
        tmp_nxt   = alu_res[VAL_W-1:0];
        state_nxt = S_GAP2;
      end
      S_GAP2: begin
        alu_req.op = ALU_ADD;
        alu_req.a  = gap_r;
        alu_req.b  = tmp_r;
        if (alu_res[VAL_W]) begin
          gap_nxt    = '1;
          sticky_nxt = 1'b1;
        end else begin
          gap_nxt = alu_res[VAL_W-1:0];
        end
        state_nxt = S_FIN;
      end
      S_INSERT: begin
        tbl_wr.key_en  = 1'b1;
        tbl_wr.mark_en = 1'b1;
        tbl_wr.addr    = ins_slot;
        if (in_use_r < CNT_W'(CAPACITY)) begin
          in_use_nxt = in_use_r + CNT_W'(1);
        end else begin
          repl_nxt  = (repl_r == IDX_W'(CAPACITY - 1)) ? '0 : repl_r + IDX_W'(1);
          evict_nxt = evict_r + 64'd1;
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (fill_r >= CNT_W'(CAPACITY)) begin
          ovw_nxt = ovw_r + 64'd1;
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        acc_nxt   = acc_r + 64'd1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = take ? S_EXP : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      in_use_r  <= '0;
      repl_r    <= '0;
      fill_r    <= '0;
      inv_cnt_r <= '0;
      exp_cnt_r <= '0;
      cat_cnt_r <= '0;
      evict_r   <= '0;
      gap_r     <= '0;
      sticky_r  <= 1'b0;
      ovw_r     <= '0;
      acc_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      in_use_r  <= in_use_nxt;
      repl_r    <= repl_nxt;
      fill_r    <= fill_nxt;
      inv_cnt_r <= inv_cnt_nxt;
      exp_cnt_r <= exp_cnt_nxt;
      cat_cnt_r <= cat_cnt_nxt;
      evict_r   <= evict_nxt;
      gap_r     <= gap_nxt;
      sticky_r  <= sticky_nxt;
      ovw_r     <= ovw_nxt;
      acc_r     <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    tmp_r    <= tmp_nxt;
    status_r <= status_nxt;
  end

  // ---------------- result word ----------------
  assign out_valid                 = (state_r == S_DONE);
  assign out_status                = status_r;
  assign out_invalid_count         = inv_cnt_r;
  assign out_expired_count         = exp_cnt_r;
  assign out_category_reject_count = cat_cnt_r;
  assign out_stream_eviction_count = evict_r;
  assign out_gap_total             = gap_r;
  assign out_gap_saturated         = sticky_r;
  assign out_overwrite_count       = ovw_r;
  assign out_accepted_count        = acc_r;
  assign out_stored_events         = fill_r;

  // ---------------- assertions ----------------
  a_valid_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !take |=> !out_valid)
    else $error("result word held past one cycle");

  a_take_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> busy)
    else $error("accepted word did not start the sequencer");

  a_in_use_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_use_r <= CNT_W'(CAPACITY)) && (fill_r <= CNT_W'(CAPACITY)))
    else $error("occupancy beyond capacity");

  a_sticky_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    sticky_r |-> (gap_r == '1))
    else $error("gap sticky set but total not saturated");

endmodule
